// ----- rtl/core/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// dda_pkg: shared types and constants for the DDA ray setup block
// Register indexes and the per-stage record of the reciprocal pipeline.
// ----------------------------------------------------------------------------
package dda_pkg;

    typedef enum logic [2:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5
    } reg_index_t;

    // quotient bits of floor(2^32 / mag): bit 32 down to bit 0
    localparam int DIV_STEPS = 33;

    typedef struct packed {
        logic               vld;
        logic signed [18:0] rdx;
        logic signed [18:0] rdy;
        logic [18:0]        magx;
        logic [18:0]        magy;
        logic [18:0]        remx;
        logic [18:0]        remy;
        logic [32:0]        qx;
        logic [32:0]        qy;
    } div_t;

endpackage

// ----- rtl/core/dda_recip_stage.sv -----
// ----------------------------------------------------------------------------
// dda_recip_stage: one restoring-division step for both ray axes
// Shifts one dividend bit into each remainder and settles one quotient bit.
// ----------------------------------------------------------------------------
module dda_recip_stage
    import dda_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic num_bit,
    input  div_t d_in,
    output div_t d_out
);

    div_t        stage_reg;
    div_t        stage_next;
    logic [19:0] shx;
    logic [19:0] shy;
    logic        gex;
    logic        gey;

    always_comb begin
        shx = {d_in.remx, num_bit};
        shy = {d_in.remy, num_bit};
        gex = shx >= {1'b0, d_in.magx};
        gey = shy >= {1'b0, d_in.magy};
        stage_next      = d_in;
        stage_next.remx = gex ? 19'(shx - {1'b0, d_in.magx}) : shx[18:0];
        stage_next.remy = gey ? 19'(shy - {1'b0, d_in.magy}) : shy[18:0];
        stage_next.qx   = {d_in.qx[31:0], gex};
        stage_next.qy   = {d_in.qy[31:0], gey};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.vld <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign d_out = stage_reg;

endmodule

// ----- rtl/core/dda_ray_setup.sv -----
// ----------------------------------------------------------------------------
// dda_ray_setup: per-column ray setup for grid-traversal ray casting
// Forms camera coordinate, ray direction, start cell, delta and side dists.
// ----------------------------------------------------------------------------
// Usage:
//   Write the camera registers on cfg_* while the block is idle. Send one
//   screen column per request on s_axis; one ray record leaves on m_axis per
//   column, in order. A request is taken on any edge where tvalid and tready
//   are both high.
//   The depth is five setup stages (column clamp and reciprocal product,
//   quotient estimate, remainder fix, plane products, direction sum), 33
//   restoring-division steps for |1/ray_dir|, and two side-distance
//   stages. Throughput is one column per cycle while m_axis_tready is
//   high; the division pipeline sets the depth, one quotient bit per stage.
//   Each stage holds its data while its successor is full and stalled, so
//   a stall on m_axis_tready fills the bubbles first and then pushes back
//   on s_axis_tready; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the default camera.
// ----------------------------------------------------------------------------
module dda_ray_setup
    import dda_pkg::*;
#(
    parameter int SCREEN_WIDTH = 1024
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // column[9:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ray_dx, ray_dy, cell_x, cell_y, delta_x, delta_y,
    // step_x_neg, step_y_neg, side_x, side_y
    output logic [183:0] m_axis_tdata
);

    localparam logic [12:0] WMAX  = 13'(SCREEN_WIDTH - 1);
    localparam logic [12:0] WVAL  = 13'(SCREEN_WIDTH);
    localparam logic [29:0] RECIP = 30'((64'd1 << 30) / SCREEN_WIDTH);

    // camera registers
    logic [23:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= 18'sd65536;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 18'sd43254;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_wdata;
                REG_POS_Y:   pos_y_reg   <= cfg_wdata;
                REG_DIR_X:   dir_x_reg   <= cfg_wdata[17:0];
                REG_DIR_Y:   dir_y_reg   <= cfg_wdata[17:0];
                REG_PLANE_X: plane_x_reg <= cfg_wdata[17:0];
                REG_PLANE_Y: plane_y_reg <= cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // stage enables
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;
    logic [DIV_STEPS-1:0] en_div;
    div_t div_q [DIV_STEPS];
    div_t div_d [DIV_STEPS];

    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg, v_f_reg, v_o_reg;

    always_comb begin
        en_o = !v_o_reg || m_axis_tready;
        en_f = !v_f_reg || en_o;
        en_div[DIV_STEPS-1] = !div_q[DIV_STEPS-1].vld || en_f;
        for (int k = DIV_STEPS - 2; k >= 0; k--) begin
            en_div[k] = !div_q[k].vld || en_div[k+1];
        end
        en_e = !v_e_reg || en_div[0];
        en_d = !v_d_reg || en_e;
        en_c = !v_c_reg || en_d;
        en_b = !v_b_reg || en_c;
        en_a = !v_a_reg || en_b;
    end

    assign s_axis_tready = en_a;

    // stage a: clamp column, multiply by reciprocal of width
    logic [9:0]  col_in;
    logic [9:0]  colc_a_reg;
    logic [39:0] p1_a_reg;

    always_comb begin
        col_in = s_axis_tdata[9:0];
        if ({3'b000, col_in} > WMAX) begin
            col_in = WMAX[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
        end else if (en_a) begin
            v_a_reg <= s_axis_tvalid;
        end
        if (en_a) begin
            colc_a_reg <= col_in;
            p1_a_reg   <= 40'(col_in) * 40'(RECIP);
        end
    end

    // stage b: estimate quotient, low by at most one
    logic [9:0]  colc_b_reg;
    logic [16:0] q0_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b_reg <= 1'b0;
        end else if (en_b) begin
            v_b_reg <= v_a_reg;
        end
        if (en_b) begin
            colc_b_reg <= colc_a_reg;
            q0_b_reg   <= p1_a_reg[29:13];
        end
    end

    // stage c: correct quotient, form camera coordinate
    logic [27:0]        num_c;
    logic [29:0]        qw_c;
    logic [27:0]        rem_c;
    logic [16:0]        q_c;
    logic signed [17:0] cam_c_reg;

    always_comb begin
        num_c = {1'b0, colc_b_reg, 17'd0};
        qw_c  = 30'(q0_b_reg) * 30'(WVAL);
        rem_c = num_c - qw_c[27:0];
        q_c   = (rem_c >= 28'(WVAL)) ? 17'(q0_b_reg + 17'd1) : q0_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg <= 1'b0;
        end else if (en_c) begin
            v_c_reg <= v_b_reg;
        end
        if (en_c) begin
            cam_c_reg <= signed'(18'({1'b0, q_c}) - 18'd65536);
        end
    end

    // stage d: plane * cam
    logic signed [35:0] px_d_reg, py_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_d_reg <= 1'b0;
        end else if (en_d) begin
            v_d_reg <= v_c_reg;
        end
        if (en_d) begin
            px_d_reg <= 36'(plane_x_reg) * 36'(cam_c_reg);
            py_d_reg <= 36'(plane_y_reg) * 36'(cam_c_reg);
        end
    end

    // stage e: add direction, saturate, take magnitude
    logic signed [20:0] sx_e, sy_e;
    logic signed [18:0] rx_e, ry_e;
    logic signed [18:0] rdx_e_reg, rdy_e_reg;
    logic [18:0]        magx_e_reg, magy_e_reg;

    function automatic logic signed [18:0] sat19(input logic signed [20:0] v);
        logic signed [18:0] r;
        if (v > 21'sd262143) begin
            r = 19'sd262143;
        end else if (v < -21'sd262144) begin
            r = -19'sd262144;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

    always_comb begin
        sx_e = 21'(dir_x_reg) + 21'(px_d_reg >>> 16);
        sy_e = 21'(dir_y_reg) + 21'(py_d_reg >>> 16);
        rx_e = sat19(sx_e);
        ry_e = sat19(sy_e);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_e_reg <= 1'b0;
        end else if (en_e) begin
            v_e_reg <= v_d_reg;
        end
        if (en_e) begin
            rdx_e_reg  <= rx_e;
            rdy_e_reg  <= ry_e;
            magx_e_reg <= rx_e[18] ? 19'(-rx_e) : rx_e;
            magy_e_reg <= ry_e[18] ? 19'(-ry_e) : ry_e;
        end
    end

    // reciprocal pipeline: dividend is 2^32, top bit first
    always_comb begin
        div_d[0]      = '0;
        div_d[0].vld  = v_e_reg;
        div_d[0].rdx  = rdx_e_reg;
        div_d[0].rdy  = rdy_e_reg;
        div_d[0].magx = magx_e_reg;
        div_d[0].magy = magy_e_reg;
        for (int k = 1; k < DIV_STEPS; k++) begin
            div_d[k] = div_q[k-1];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        dda_recip_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en_div[k]),
            .num_bit (k == 0),
            .d_in    (div_d[k]),
            .d_out   (div_q[k])
        );
    end

    // stage f: saturate delta, fraction times delta
    div_t               dl;
    logic [31:0]        dx_f, dy_f;
    logic [16:0]        distx_f, disty_f;
    logic signed [18:0] rdx_f_reg, rdy_f_reg;
    logic [31:0]        dx_f_reg, dy_f_reg;
    logic [48:0]        sx_f_reg, sy_f_reg;

    always_comb begin
        dl      = div_q[DIV_STEPS-1];
        dx_f    = dl.qx[32] ? 32'hFFFF_FFFF : dl.qx[31:0];
        dy_f    = dl.qy[32] ? 32'hFFFF_FFFF : dl.qy[31:0];
        distx_f = dl.rdx[18] ? {1'b0, pos_x_reg[15:0]}
                             : 17'(17'h10000 - {1'b0, pos_x_reg[15:0]});
        disty_f = dl.rdy[18] ? {1'b0, pos_y_reg[15:0]}
                             : 17'(17'h10000 - {1'b0, pos_y_reg[15:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_f_reg <= 1'b0;
        end else if (en_f) begin
            v_f_reg <= dl.vld;
        end
        if (en_f) begin
            rdx_f_reg <= dl.rdx;
            rdy_f_reg <= dl.rdy;
            dx_f_reg  <= dx_f;
            dy_f_reg  <= dy_f;
            sx_f_reg  <= 49'(distx_f) * 49'(dx_f);
            sy_f_reg  <= 49'(disty_f) * 49'(dy_f);
        end
    end

    // output stage: saturate side distances
    logic signed [18:0] rdx_o_reg, rdy_o_reg;
    logic [31:0]        dx_o_reg, dy_o_reg, sx_o_reg, sy_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_o_reg <= 1'b0;
        end else if (en_o) begin
            v_o_reg <= v_f_reg;
        end
        if (en_o) begin
            rdx_o_reg <= rdx_f_reg;
            rdy_o_reg <= rdy_f_reg;
            dx_o_reg  <= dx_f_reg;
            dy_o_reg  <= dy_f_reg;
            sx_o_reg  <= sx_f_reg[48] ? 32'hFFFF_FFFF : sx_f_reg[47:16];
            sy_o_reg  <= sy_f_reg[48] ? 32'hFFFF_FFFF : sy_f_reg[47:16];
        end
    end

    assign m_axis_tvalid = v_o_reg;
    assign m_axis_tdata  = {sy_o_reg, sx_o_reg, rdy_o_reg[18], rdx_o_reg[18],
                            dy_o_reg, dx_o_reg, pos_y_reg[23:16], pos_x_reg[23:16],
                            rdy_o_reg, rdx_o_reg};

endmodule

// ----- tb/tb_dda_ray_setup.sv -----
// ----------------------------------------------------------------------------
// tb_dda_ray_setup: self-checking bench for the DDA ray setup block
// Drives screen columns under several camera settings, predicts each ray
// record in fixed point and checks every m_axis record against it in order.
// Random bursts and gaps on the sender, and stall patterns on the receiver.
// ----------------------------------------------------------------------------
module tb_dda_ray_setup
    import dda_pkg::*;
();

    localparam int SCREEN_W = 1024;

    // packed so that the last member lands in the lowest tdata bits
    typedef struct packed {
        logic [31:0]        side_y;
        logic [31:0]        side_x;
        logic               step_y_neg;
        logic               step_x_neg;
        logic [31:0]        delta_y;
        logic [31:0]        delta_x;
        logic [7:0]         cell_y;
        logic [7:0]         cell_x;
        logic signed [18:0] ray_dy;
        logic signed [18:0] ray_dx;
    } ray_rec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = 3'd0;
    logic [23:0]  cfg_wdata = 24'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = 16'd0;   // column[9:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // ray_dx, ray_dy, cell_x, cell_y, delta_x, delta_y,
    // step_x_neg, step_y_neg, side_x, side_y
    logic [183:0] m_axis_tdata;

    dda_ray_setup #(.SCREEN_WIDTH(SCREEN_W)) dut (.*);

    always #2 aclk = ~aclk;

    // camera shadow
    logic [23:0]        cam_pos_x = 24'd0;
    logic [23:0]        cam_pos_y = 24'd0;
    logic signed [17:0] cam_dir_x = 18'sd65536;
    logic signed [17:0] cam_dir_y = 18'sd0;
    logic signed [17:0] cam_plane_x = 18'sd0;
    logic signed [17:0] cam_plane_y = 18'sd43254;

    ray_rec_t pending_rays[$];
    int       mismatches = 0;
    int       hold_req_seq = 0;
    int       hold_seen = 0;
    int       hold_cnt = 0;
    int       burst_left = 0;

    function automatic longint ray_axis(longint d, longint p, longint cam);
        longint r;
        r = d + ((p * cam) >>> 16);
        if (r > 262143) r = 262143;
        if (r < -262144) r = -262144;
        return r;
    endfunction

    function automatic logic [31:0] recip_mag(longint rd);
        longint unsigned mag, q;
        mag = (rd < 0) ? -rd : rd;
        if (mag == 0) return 32'hFFFF_FFFF;
        q = (64'd1 << 32) / mag;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [31:0] side_dist(logic [23:0] pos, logic neg, logic [31:0] dl);
        longint unsigned span, s;
        span = neg ? pos[15:0] : 64'd65536 - pos[15:0];
        s = (span * dl) >> 16;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic ray_rec_t predict_ray(logic [9:0] col_in);
        ray_rec_t r;
        longint   col, cam, rdx, rdy;
        col = col_in;
        if (col > SCREEN_W - 1) col = SCREEN_W - 1;
        cam = (2 * col * 65536) / SCREEN_W - 65536;
        rdx = ray_axis(cam_dir_x, cam_plane_x, cam);
        rdy = ray_axis(cam_dir_y, cam_plane_y, cam);
        r.ray_dx     = rdx[18:0];
        r.ray_dy     = rdy[18:0];
        r.cell_x     = cam_pos_x[23:16];
        r.cell_y     = cam_pos_y[23:16];
        r.delta_x    = recip_mag(rdx);
        r.delta_y    = recip_mag(rdy);
        r.step_x_neg = rdx < 0;
        r.step_y_neg = rdy < 0;
        r.side_x     = side_dist(cam_pos_x, r.step_x_neg, r.delta_x);
        r.side_y     = side_dist(cam_pos_y, r.step_y_neg, r.delta_y);
        return r;
    endfunction

    // predict on every accepted request
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            pending_rays.push_back(predict_ray(s_axis_tdata[9:0]));
    end

    // check every accepted record against the oldest prediction
    always @(posedge aclk) begin
        ray_rec_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = ray_rec_t'(m_axis_tdata);
            if (pending_rays.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected ray record %h", m_axis_tdata);
            end else begin
                want = pending_rays.pop_front();
                if (got.ray_dx !== want.ray_dx || got.ray_dy !== want.ray_dy ||
                    got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
                    got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
                    got.step_x_neg !== want.step_x_neg ||
                    got.step_y_neg !== want.step_y_neg ||
                    got.side_x !== want.side_x || got.side_y !== want.side_y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ray mismatch: rd %0d,%0d cell %0d,%0d d %h,%h st %b%b s %h,%h",
                                 got.ray_dx, got.ray_dy, got.cell_x, got.cell_y,
                                 got.delta_x, got.delta_y, got.step_x_neg, got.step_y_neg,
                                 got.side_x, got.side_y);
                        $display("      expected: rd %0d,%0d cell %0d,%0d d %h,%h st %b%b s %h,%h",
                                 want.ray_dx, want.ray_dy, want.cell_x, want.cell_y,
                                 want.delta_x, want.delta_y, want.step_x_neg, want.step_y_neg,
                                 want.side_x, want.side_y);
                    end
                end
            end
        end
    end

    // receiver: long hold-off on request, otherwise a rotating stall pattern
    always @(negedge aclk) begin
        int mode;
        mode = ($time / 256) % 4;
        if (hold_seen != hold_req_seq) begin
            hold_seen = hold_req_seq;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_POS_X:   cam_pos_x   = val;
            REG_POS_Y:   cam_pos_y   = val;
            REG_DIR_X:   cam_dir_x   = val[17:0];
            REG_DIR_Y:   cam_dir_y   = val[17:0];
            REG_PLANE_X: cam_plane_x = val[17:0];
            REG_PLANE_Y: cam_plane_y = val[17:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_camera(logic [23:0] px, logic [23:0] py, logic [17:0] dx,
                              logic [17:0] dy, logic [17:0] plx, logic [17:0] ply);
        write_reg(REG_POS_X, px);
        write_reg(REG_POS_Y, py);
        write_reg(REG_DIR_X, {6'($urandom_range(0, 63)), dx});
        write_reg(REG_DIR_Y, {6'($urandom_range(0, 63)), dy});
        write_reg(REG_PLANE_X, {6'($urandom_range(0, 63)), plx});
        write_reg(REG_PLANE_Y, {6'($urandom_range(0, 63)), ply});
    endtask

    task automatic send_column(logic [9:0] col);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, col};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        idle_sender(1);
        while (pending_rays.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_bursts(int n);
        repeat (n) begin
            send_column($urandom_range(0, SCREEN_W - 1));
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic test_directed();
        logic [9:0] cols[7] = '{0, 1, 511, 512, 513, 1022, 1023};
        // reset camera first
        foreach (cols[i]) send_column(cols[i]);
        drain();
        set_camera(24'hFFFFFF, 24'h000000, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000);
        send_column(0); send_column(512); send_column(1023);
        drain();
        // zero direction on x, one LSB on y, then minus one LSB
        set_camera(24'h010000, 24'hFF8000, 18'h00000, 18'h00001, 18'h00000, 18'h00000);
        send_column(0); send_column(1023);
        drain();
        write_reg(REG_DIR_Y, 24'h03FFFF);
        // unknown indexes must not disturb the camera
        write_reg(3'd6, 24'hABCDEF);
        write_reg(3'd7, 24'h123456);
        send_column(0); send_column(700);
        drain();
        // ray component crosses zero at the center column
        set_camera(24'h7F0001, 24'h00FFFF, 18'h00000, 18'h00000, 18'h10000, 18'h3_0000);
        send_column(511); send_column(512); send_column(513);
        drain();
    endtask

    task automatic test_random_cameras();
        for (int ph = 0; ph < 7; ph++) begin
            set_camera($urandom_range(0, 3) == 0 ? {8'($urandom_range(0, 255)), 16'h0}
                                                 : 24'($urandom),
                       24'($urandom), 18'($urandom), 18'($urandom),
                       18'($urandom), 18'($urandom));
            send_bursts(100);
            drain();
        end
    endtask

    task automatic test_backpressure();
        set_camera(24'($urandom), 24'($urandom), 18'h10000, 18'h0, 18'h0, 18'h0A8F6);
        hold_req_seq++;
        repeat (120) send_column($urandom_range(0, SCREEN_W - 1));
        drain();
    endtask

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_cameras();
        drain();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
